// ===== hdl/ktls_pkg.sv =====
package ktls_pkg;

    localparam int CAPACITY    = 64;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 38;
    localparam int RANK_W      = 7;
    localparam int COUNT_OUT_W = 7;
    localparam int CMP_W       = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    vld;
        logic                    lt;
        logic                    le;
        logic                    eq;
        logic signed [VAL_W-1:0] val_next;
        logic                    vld_next;
    } cell_stat_t;

endpackage

// ===== hdl/ktls_cell.sv =====
module ktls_cell
    import ktls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] key,
    input  logic signed [VAL_W-1:0] left_val,
    input  logic                    left_vld,
    input  logic                    left_lt,
    input  logic signed [VAL_W-1:0] right_val,
    input  logic                    right_vld,
    output cell_stat_t              stat
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    vld_reg;
    logic                    vld_next;
    logic                    lt;
    logic                    le;
    logic                    eq;

    // an empty cell counts as below the key, so inserts and removals land at the tail
    assign lt = !vld_reg || (val_reg < key);
    assign le = !vld_reg || (val_reg <= key);
    assign eq = vld_reg && (val_reg == key);

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctl.ins_en)
        begin
            vld_next = vld_reg | left_vld;
            if (lt)
            begin
                // first cell below the key takes it, the rest take their left neighbor
                val_next = left_lt ? left_val : key;
            end
        end
        else if (ctl.rem_en)
        begin
            vld_next = right_vld;
            if (le)
            begin
                val_next = right_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign stat.val      = val_reg;
    assign stat.vld      = vld_reg;
    assign stat.lt       = lt;
    assign stat.le       = le;
    assign stat.eq       = eq;
    assign stat.val_next = val_next;
    assign stat.vld_next = vld_next;

endmodule

// ===== hdl/kth_largest_tracker_sums.sv =====
// The result is registered at the edge that accepts the item.
// Throughput: one item per cycle while out_ready is high; the row of cells
// compares and shifts the whole sorted store in parallel.
// Reset clears the cell valid bits, the count and both totals, and sets
// the rank register to 1; no clearing pass is needed, so items are taken right after reset.
module kth_largest_tracker_sums
    import ktls_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [RANK_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [COUNT_OUT_W-1:0]   count,
    output logic                     kth_valid,
    output logic signed [VAL_W-1:0]  kth_value,
    output logic signed [SUM_W-1:0]  top_sum,
    output logic signed [SUM_W-1:0]  rest_sum
);

    cell_stat_t              stat [CAPACITY];
    cell_ctl_t               ctl;

    logic [RANK_W-1:0]       rank_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [SUM_W-1:0] top_reg;
    logic signed [SUM_W-1:0] top_next;
    logic signed [SUM_W-1:0] rest_reg;
    logic signed [SUM_W-1:0] rest_next;

    logic                    out_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic                    kth_valid_reg;
    logic signed [VAL_W-1:0] kth_value_reg;
    logic signed [VAL_W-1:0] kth_value_next;

    logic                    in_fire;
    logic                    full;
    logic                    found;
    logic [RANK_W-1:0]       k_eff;
    logic [CAPACITY-1:0]     vld_vec;
    logic [CAPACITY-1:0]     eq_vec;
    logic [CAPACITY-1:0]     vn_vec;
    logic [CAPACITY-1:0]     grp_vec;
    logic signed [VAL_W-1:0] tap_a_val;
    logic signed [VAL_W-1:0] tap_b_val;
    logic                    tap_a_lt;
    logic                    tap_a_le;
    logic                    n_lt_k;
    logic                    n_le_k;
    logic signed [SUM_W-1:0] v_ext;
    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] b_ext;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign k_eff    = (rank_reg == '0) ? RANK_W'(1) : rank_reg;
    assign full     = stat[CAPACITY-1].vld;
    assign found    = |eq_vec;

    assign ctl.ins_en = in_fire && (op_t'(op) == OP_INSERT) && !full;
    assign ctl.rem_en = in_fire && (op_t'(op) == OP_REMOVE) && found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] l_val;
        logic                    l_vld;
        logic                    l_lt;
        logic signed [VAL_W-1:0] r_val;
        logic                    r_vld;

        if (i == 0)
        begin : g_head
            assign l_val = value;
            assign l_vld = 1'b1;
            assign l_lt  = 1'b0;
        end
        else
        begin : g_body
            assign l_val = stat[i-1].val;
            assign l_vld = stat[i-1].vld;
            assign l_lt  = stat[i-1].lt;
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign r_val = value;
            assign r_vld = 1'b0;
        end
        else
        begin : g_mid
            assign r_val = stat[i+1].val;
            assign r_vld = stat[i+1].vld;
        end

        ktls_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .key       (value),
            .left_val  (l_val),
            .left_vld  (l_vld),
            .left_lt   (l_lt),
            .right_val (r_val),
            .right_vld (r_vld),
            .stat      (stat[i])
        );
    end

    // taps at rank k and k+1, and the reported entry after the update
    always_comb
    begin
        tap_a_val      = '0;
        tap_b_val      = '0;
        tap_a_lt       = 1'b0;
        tap_a_le       = 1'b0;
        kth_value_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            vld_vec[i] = stat[i].vld;
            eq_vec[i]  = stat[i].eq;
            vn_vec[i]  = stat[i].vld_next;
            grp_vec[i] = (i < int'(k_eff));
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (int'(k_eff) == i + 1)
            begin
                tap_a_val = tap_a_val | stat[i].val;
                tap_a_lt  = tap_a_lt | stat[i].lt;
                tap_a_le  = tap_a_le | stat[i].le;
            end
            if (int'(k_eff) == i)
            begin
                tap_b_val = tap_b_val | stat[i].val;
            end
            // last held entry inside the top group
            if (vn_vec[i] && grp_vec[i] &&
                ((i == CAPACITY - 1) || !vn_vec[(i + 1) % CAPACITY] ||
                 !grp_vec[(i + 1) % CAPACITY]))
            begin
                kth_value_next = kth_value_next | stat[i].val_next;
            end
        end
    end

    assign n_lt_k = CMP_W'(count_reg) <  CMP_W'(k_eff);
    assign n_le_k = CMP_W'(count_reg) <= CMP_W'(k_eff);
    assign v_ext  = SUM_W'(value);
    assign a_ext  = SUM_W'(tap_a_val);
    assign b_ext  = SUM_W'(tap_b_val);

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        rest_next  = rest_reg;
        if (ctl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
            if (n_lt_k)
            begin
                top_next = top_reg + v_ext;
            end
            else if (tap_a_lt)
            begin
                // the old k-th entry drops into the rest
                top_next  = top_reg + v_ext - a_ext;
                rest_next = rest_reg + a_ext;
            end
            else
            begin
                rest_next = rest_reg + v_ext;
            end
        end
        else if (ctl.rem_en)
        begin
            count_next = count_reg - CNT_W'(1);
            if (n_le_k)
            begin
                top_next = top_reg - v_ext;
            end
            else if (tap_a_le)
            begin
                // the old (k+1)-th entry moves up into the top group
                top_next  = top_reg + b_ext - v_ext;
                rest_next = rest_reg - b_ext;
            end
            else
            begin
                rest_next = rest_reg - v_ext;
            end
        end
    end

    always_comb
    begin
        status_next = ST_DONE;
        if (op_t'(op) == OP_INSERT && full)
        begin
            status_next = ST_FULL;
        end
        else if (op_t'(op) == OP_REMOVE && !found)
        begin
            status_next = ST_ABSENT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= RANK_W'(1);
            count_reg     <= '0;
            top_reg       <= '0;
            rest_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && count_reg == '0)
            begin
                rank_reg <= cfg_data;
            end
            count_reg <= count_next;
            top_reg   <= top_next;
            rest_reg  <= rest_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg    <= status_next;
            kth_valid_reg <= (count_next != '0);
            kth_value_reg <= (count_next != '0) ? kth_value_next : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = COUNT_OUT_W'(count_reg);
    assign kth_valid = kth_valid_reg;
    assign kth_value = kth_value_reg;
    assign top_sum   = top_reg;
    assign rest_sum  = rest_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("count above capacity");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) == int'(count_reg))
        else $error("count disagrees with cell valid bits");

    a_full_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op_t'(op) == OP_INSERT && full) |=> $stable(count_reg) && $stable(top_reg))
        else $error("rejected insert changed the store");

    a_absent_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op_t'(op) == OP_REMOVE && !found) |=> $stable(count_reg) && $stable(rest_reg))
        else $error("rejected remove changed the store");

    a_kth_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (kth_valid_reg == (count_reg != '0)))
        else $error("kth_valid disagrees with count");
`endif

endmodule

// ===== verif/kth_largest_tracker_sums_checker.sv =====
module kth_largest_tracker_sums_checker
    import ktls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [RANK_W-1:0]       cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    op,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [1:0]              status,
    input  logic [COUNT_OUT_W-1:0]  count,
    input  logic                    kth_valid,
    input  logic signed [VAL_W-1:0] kth_value,
    input  logic signed [SUM_W-1:0] top_sum,
    input  logic signed [SUM_W-1:0] rest_sum,
    output int                      mismatches,
    output int                      awaiting
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t                 status;
        logic [COUNT_OUT_W-1:0]  count;
        logic                    kth_valid;
        logic signed [VAL_W-1:0] kth_value;
        logic signed [SUM_W-1:0] top_sum;
        logic signed [SUM_W-1:0] rest_sum;
    } tracker_result_t;

    // predictor state: values held in descending order
    logic signed [VAL_W-1:0] ranked [CAPACITY];
    int                      held;
    logic [RANK_W-1:0]       rank;
    tracker_result_t         due_results [$];
    tracker_result_t         exp_res;
    logic                    bad;

    function automatic void rank_and_total(op_t o, logic signed [VAL_W-1:0] v);
        status_t         st;
        int              pos;
        int              grp;
        longint          hi;
        longint          lo;
        tracker_result_t r;
        st = ST_DONE;
        pos = 0;
        if (o == OP_INSERT)
        begin
            if (held >= CAPACITY)
                st = ST_FULL;
            else
            begin
                while (pos < held && ranked[pos] >= v)
                    pos++;
                for (int i = held; i > pos; i--)
                    ranked[i] = ranked[i-1];
                ranked[pos] = v;
                held++;
            end
        end
        else
        begin
            while (pos < held && ranked[pos] != v)
                pos++;
            if (pos == held)
                st = ST_ABSENT;
            else
            begin
                for (int i = pos; i + 1 < held; i++)
                    ranked[i] = ranked[i+1];
                held--;
            end
        end
        // a rank of zero behaves as one; the group never exceeds what is held
        grp = (rank == '0) ? 1 : int'(rank);
        if (grp > held)
            grp = held;
        hi = 0;
        lo = 0;
        for (int i = 0; i < held; i++)
        begin
            if (i < grp)
                hi += ranked[i];
            else
                lo += ranked[i];
        end
        r.status    = st;
        r.count     = COUNT_OUT_W'(held);
        r.kth_valid = (held != 0);
        r.kth_value = (held != 0) ? ranked[grp-1] : '0;
        r.top_sum   = SUM_W'(hi);
        r.rest_sum  = SUM_W'(lo);
        due_results.push_back(r);
    endfunction

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
        held       = 0;
        rank       = RANK_W'(1);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            rank = RANK_W'(1);
            due_results.delete();
        end
        else
        begin
            // k only takes effect while nothing is held
            if (cfg_we && held == 0)
                rank = cfg_data;
            if (in_valid && in_ready)
                rank_and_total(op_t'(op), value);
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected item: status %0d count %0d kth %0d/%0d sums %0d %0d",
                                 $time, status, count, kth_valid, kth_value, top_sum, rest_sum);
                end
                else
                begin
                    exp_res = due_results.pop_front();
                    bad = (status    !== exp_res.status)    ||
                          (count     !== exp_res.count)     ||
                          (kth_valid !== exp_res.kth_valid) ||
                          (kth_value !== exp_res.kth_value) ||
                          (top_sum   !== exp_res.top_sum)   ||
                          (rest_sum  !== exp_res.rest_sum);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch, expected status %0d count %0d kth %0d/%0d sums %0d %0d",
                                     $time, exp_res.status, exp_res.count, exp_res.kth_valid,
                                     exp_res.kth_value, exp_res.top_sum, exp_res.rest_sum);
                            $display("%0t:           actual   status %0d count %0d kth %0d/%0d sums %0d %0d",
                                     $time, status, count, kth_valid, kth_value, top_sum, rest_sum);
                        end
                    end
                end
            end
        end
        awaiting = due_results.size();
    end

endmodule

// ===== verif/kth_largest_tracker_sums_test.sv =====
module kth_largest_tracker_sums_test;
    import ktls_pkg::*;

    localparam int ITEMS       = 1250;
    localparam int SEGMENTS    = 10;
    localparam int CYCLE_LIMIT = 100000;

    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [RANK_W-1:0]       cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    op_t                     item_op;
    logic signed [VAL_W-1:0] value;
    logic                    out_valid;
    logic                    out_ready;
    logic [1:0]              status;
    logic [COUNT_OUT_W-1:0]  count;
    logic                    kth_valid;
    logic signed [VAL_W-1:0] kth_value;
    logic signed [SUM_W-1:0] top_sum;
    logic signed [SUM_W-1:0] rest_sum;

    int fail_total;
    int results_due;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;

    // values the store should hold, used to aim removals at present values
    logic [VAL_W-1:0] held_vals [$];

    kth_largest_tracker_sums u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (item_op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .count     (count),
        .kth_valid (kth_valid),
        .kth_value (kth_value),
        .top_sum   (top_sum),
        .rest_sum  (rest_sum)
    );

    kth_largest_tracker_sums_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (item_op),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .count      (count),
        .kth_valid  (kth_valid),
        .kth_value  (kth_value),
        .top_sum    (top_sum),
        .rest_sum   (rest_sum),
        .mismatches (fail_total),
        .awaiting   (results_due)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        item_op   = OP_INSERT;
        value     = '0;
        out_ready = 1'b0;
        cycles    = 0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("kth_largest_tracker_sums_test failed");
            $finish;
        end
    end

    task automatic push_item(input op_t o, input logic [VAL_W-1:0] v);
        int idx;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        item_op  <= o;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (o == OP_INSERT)
        begin
            if (held_vals.size() < CAPACITY)
                held_vals.push_back(v);
        end
        else
        begin
            idx = 0;
            while (idx < held_vals.size() && held_vals[idx] != v)
                idx++;
            if (idx < held_vals.size())
                held_vals.delete(idx);
        end
    endtask

    // drop valid and hold until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        @(posedge clk);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] k);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= k;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic empty_store();
        while (held_vals.size() > 0)
            push_item(OP_REMOVE, held_vals[$urandom_range(held_vals.size() - 1)]);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input int style, input int seg);
        logic [VAL_W-1:0] edges [7];
        edges = '{VAL_MIN, VAL_MAX, 32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0001, 32'h7fff_fffe};
        case (style)
            0:
            begin
                case ($urandom_range(3))
                    1: return VAL_W'($urandom_range(16) - 8);
                    2: return edges[$urandom_range(6)];
                    default: return $urandom;
                endcase
            end
            1: return edges[$urandom_range(6)];
            2: return VAL_W'($urandom_range(8) - 4);
            default: return (seg < 5) ? VAL_MIN : VAL_MAX;
        endcase
    endfunction

    initial
    begin
        logic [RANK_W-1:0] ranks [SEGMENTS];
        int               n;
        int               style;
        bit               grow;
        ranks = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd1, 7'd63, 7'd32, 7'd2, 7'd65, 7'd0};
        ranks[SEGMENTS-1] = RANK_W'($urandom_range(127));
        send_idle_pct = 6;
        recv_idle_pct = 50;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, absent values, duplicates, odd ranks
        push_item(OP_REMOVE, 32'd5);
        push_item(OP_INSERT, VAL_MAX);
        push_item(OP_INSERT, VAL_MIN);
        push_item(OP_INSERT, 32'd0);
        push_item(OP_INSERT, 32'hffff_ffff);
        push_item(OP_REMOVE, 32'd12345);
        push_item(OP_REMOVE, VAL_MIN);
        write_rank(7'd3);   // ignored while values are held
        push_item(OP_INSERT, 32'd7);
        push_item(OP_INSERT, 32'd7);
        push_item(OP_REMOVE, 32'd7);
        empty_store();
        write_rank(7'd0);
        push_item(OP_INSERT, 32'd5);
        push_item(OP_INSERT, -32'sd5);
        push_item(OP_INSERT, 32'd5);
        empty_store();
        write_rank(7'd127);
        push_item(OP_INSERT, 32'd9);
        push_item(OP_INSERT, -32'sd9);
        push_item(OP_INSERT, 32'd0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 4)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 6;
            end
            else if (seg == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // sometimes keep values so the rank write is dropped
            if ($urandom_range(3) != 0)
                empty_store();
            write_rank(ranks[seg]);
            style = seg % 4;
            grow  = 1'b1;
            for (n = 0; n < ITEMS / SEGMENTS; n++)
            begin
                if (held_vals.size() == CAPACITY && $urandom_range(3) == 0)
                    grow = 1'b0;
                else if (held_vals.size() == 0 && $urandom_range(1) == 0)
                    grow = 1'b1;
                else if ($urandom_range(99) == 0)
                    grow = !grow;
                if ($urandom_range(9) < (grow ? 9 : 2))
                    push_item(OP_INSERT, pick_value(style, seg));
                else if (held_vals.size() > 0 && $urandom_range(99) < 85)
                    push_item(OP_REMOVE, held_vals[$urandom_range(held_vals.size() - 1)]);
                else
                    push_item(OP_REMOVE, pick_value(style, seg));
            end
        end

        settle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (fail_total == 0 && results_due == 0)
            $display("kth_largest_tracker_sums_test passed");
        else
            $display("kth_largest_tracker_sums_test failed");
        $finish;
    end

endmodule
